// File: hw/rtl/wildcard_byte_pattern_scanner_unit_assert.svh
// Assertion macros for the wildcard byte pattern scanner.
// NEXT checks the consequent in the cycle after the antecedent, SAME in the same cycle.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wbps: next-cycle check failed");
`define WBPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wbps: same-cycle check failed");
`else
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`define WBPS_ASSERT_SAME(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

   localparam int BYTE_W   = 8;
   localparam int SET_SIZE = 256;
   localparam int CFG_W    = 6;
   localparam int OFFSET_W = 32;
   localparam int POS_W    = 5;
   localparam int KIND_W   = 2;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

   localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WILD    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SET     = 2'd2;

   typedef enum logic [1:0] {
      CMD_WRITE_POS = 2'd0,
      CMD_ADD_SET   = 2'd1,
      CMD_SCAN      = 2'd2,
      CMD_RESTART   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic              write_pos;
      logic              add_set;
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] value;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/wildcard_byte_pattern_scanner_unit.sv
// Wildcard byte pattern scanner: finds a pattern of up to MAX_PATTERN_LEN positions (literal,
// wildcard or 256-entry byte set) in a byte stream and returns one response per request,
// flagging every match, overlapping ones included, with its saturating start offset. The block
// takes one transaction per cycle while responses are taken; a transaction is held in the input
// register, then passes through the per-position accept mask and the shift-and update into the
// response register. A stalled response holds the input register, so at most two transactions
// are in flight. Set maps live in per-position flip-flops cleared by reset at once, so no
// clearing pass is needed. Write csr_write_data (pattern length) only while the block is
// idle.
`default_nettype none

`include "wildcard_byte_pattern_scanner_unit_assert.svh"

module wildcard_byte_pattern_scanner_unit
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_LEN = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_command,
   input  wire logic [POS_W-1:0]    req_position,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [BYTE_W-1:0]   req_byte_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_match_found,
   output logic [OFFSET_W-1:0]      rsp_match_start,
   output logic                     rsp_offset_saturated,
   input  wire logic                csr_write_enable,
   input  wire logic [CFG_W-1:0]    csr_write_data
);

   localparam int LEN_IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

   logic                       in_vld_ff;
   logic                       in_vld_in;
   cmd_type                    in_cmd_ff;
   logic [POS_W-1:0]           in_position_ff;
   logic [KIND_W-1:0]          in_kind_ff;
   logic [BYTE_W-1:0]          in_byte_ff;
   logic                       req_take;
   logic                       move;

   logic [CFG_W-1:0]           pattern_length_ff;
   logic [CFG_W-1:0]           pattern_length_in;
   logic [CFG_W:0]             eff_len;
   logic [LEN_IDX_W-1:0]       eff_m1;

   logic [MAX_PATTERN_LEN-1:0] accept_vec;
   logic [MAX_PATTERN_LEN-1:0] pm_ff;
   logic [MAX_PATTERN_LEN-1:0] pm_in;
   logic [OFFSET_W-1:0]        offset_ff;
   logic [OFFSET_W-1:0]        offset_in;

   logic                       found;
   logic [OFFSET_W-1:0]        start;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_match_found_ff;
   logic [OFFSET_W-1:0]        rsp_match_start_ff;
   logic                       rsp_offset_saturated_ff;

   // advance the held transaction when the response register is free
   assign move      = in_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_vld_ff || move;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (move) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff      <= cmd_type'(req_command);
         in_position_ff <= req_position;
         in_kind_ff     <= req_kind;
         in_byte_ff     <= req_byte_value;
      end
   end

   assign pattern_length_in = csr_write_enable ? csr_write_data : pattern_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= CFG_W'(1);
      end else begin
         pattern_length_ff <= pattern_length_in;
      end
   end

   // clamp the length into 1..MAX_PATTERN_LEN
   always_comb begin
      if (pattern_length_ff == '0) begin
         eff_len = (CFG_W+1)'(1);
      end else if ({1'b0, pattern_length_ff} > (CFG_W+1)'(MAX_PATTERN_LEN)) begin
         eff_len = (CFG_W+1)'(MAX_PATTERN_LEN);
      end else begin
         eff_len = {1'b0, pattern_length_ff};
      end
      eff_m1 = LEN_IDX_W'(eff_len - (CFG_W+1)'(1));
   end

   for (genvar p = 0; p < MAX_PATTERN_LEN; p++) begin : g_cell
      cell_ctl_type ctl;
      logic         hit;

      assign hit = (32'(in_position_ff) == 32'(p));
      assign ctl = '{write_pos: move && (in_cmd_ff == CMD_WRITE_POS) && hit,
                     add_set:   move && (in_cmd_ff == CMD_ADD_SET) && hit,
                     kind:      in_kind_ff,
                     value:     in_byte_ff};

      wbps_pos_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .accept (accept_vec[p])
      );
   end

   always_comb begin
      pm_in     = pm_ff;
      offset_in = offset_ff;
      found     = 1'b0;
      start     = '0;
      if (move) begin
         case (in_cmd_ff)
            CMD_SCAN: begin
               pm_in = ((pm_ff << 1) | MAX_PATTERN_LEN'(1)) & accept_vec;
               found = pm_in[eff_m1];
               if (found) begin
                  start = offset_ff - OFFSET_W'(eff_m1);
               end
               if (offset_ff != OFFSET_MAX) begin
                  offset_in = offset_ff + OFFSET_W'(1);
               end
            end
            CMD_RESTART: begin
               pm_in     = '0;
               offset_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_ff     <= '0;
         offset_ff <= '0;
      end else begin
         pm_ff     <= pm_in;
         offset_ff <= offset_in;
      end
   end

   // hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_match_found_ff      <= found;
         rsp_match_start_ff      <= start;
         rsp_offset_saturated_ff <= (offset_in == OFFSET_MAX);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_match_found      = rsp_match_found_ff;
   assign rsp_match_start      = rsp_match_start_ff;
   assign rsp_offset_saturated = rsp_offset_saturated_ff;

   `WBPS_ASSERT_NEXT(a_restart_clears, clock, reset,
      move && (in_cmd_ff == CMD_RESTART), (pm_ff == '0) && (offset_ff == '0))
   `WBPS_ASSERT_NEXT(a_offset_sticks, clock, reset,
      (offset_ff == OFFSET_MAX) && !(move && (in_cmd_ff == CMD_RESTART)),
      offset_ff == OFFSET_MAX)
   `WBPS_ASSERT_NEXT(a_no_match_off_scan, clock, reset,
      move && (in_cmd_ff != CMD_SCAN), !rsp_match_found_ff)
   `WBPS_ASSERT_SAME(a_start_behind_offset, clock, reset,
      rsp_valid_ff && rsp_match_found_ff, rsp_match_start_ff <= offset_ff)

endmodule

`default_nettype wire

// File: hw/rtl/wbps_pos_cell.sv
`default_nettype none

module wbps_pos_cell
   import wbps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   output logic              accept
);

   logic [KIND_W-1:0]   kind_ff;
   logic [KIND_W-1:0]   kind_in;
   logic [BYTE_W-1:0]   literal_ff;
   logic [BYTE_W-1:0]   literal_in;
   logic [SET_SIZE-1:0] set_map_ff;
   logic [SET_SIZE-1:0] set_map_in;

   always_comb begin
      kind_in    = kind_ff;
      literal_in = literal_ff;
      set_map_in = set_map_ff;
      if (ctl.write_pos) begin
         kind_in    = ctl.kind;
         literal_in = ctl.value;
         set_map_in = '0;
      end else if (ctl.add_set) begin
         set_map_in[ctl.value] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_LITERAL;
         literal_ff <= '0;
         set_map_ff <= '0;
      end else begin
         kind_ff    <= kind_in;
         literal_ff <= literal_in;
         set_map_ff <= set_map_in;
      end
   end

   // ctl.value carries the haystack byte during a scan
   always_comb begin
      case (kind_ff)
         KIND_LITERAL: accept = (literal_ff == ctl.value);
         KIND_WILD:    accept = 1'b1;
         KIND_SET:     accept = set_map_ff[ctl.value];
         default:      accept = 1'b0;
      endcase
   end

endmodule

`default_nettype wire
